// ===== hdl/ksq_pkg.sv =====
// ----------------------------------------------------------------------------
// ksq_pkg
// Shared constants, types and codes for the keyed sorted priority queue.
// ----------------------------------------------------------------------------
`default_nettype none

package ksq_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  localparam int KEY_W    = 32;
  localparam int PRIO_W   = 31;
  localparam int STAT_W   = 3;
  localparam int COUNT_W  = 5;

  localparam int S_DATA_W = 64;
  localparam int M_DATA_W = 72;

  // Result status codes.
  typedef enum logic [STAT_W-1:0] {
    STAT_INSERTED = 3'd0,
    STAT_UPDATED  = 3'd1,
    STAT_REMOVED  = 3'd2,
    STAT_IGNORED  = 3'd3,
    STAT_DROPPED  = 3'd4
  } status_e;

  // Controller states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_PLACE
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // capture the incoming word
    logic search;  // find the key and drop its slot
    logic finish;  // place the entry and load the result register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;  // result register can take a new word this cycle
  } sts_t;

endpackage

`default_nettype wire

// ===== hdl/ksq_ctrl.sv =====
// ----------------------------------------------------------------------------
// ksq_ctrl
// Sequencer: accepts a word, then steps it through search and placement.
// ----------------------------------------------------------------------------
`default_nettype none

module ksq_ctrl (
  input  wire           clk_i,
  input  wire           rst_ni,
  input  wire           s_valid_i,
  output logic          s_ready_o,
  input  ksq_pkg::sts_t sts_i,
  output ksq_pkg::cmd_t cmd_o
);
  import ksq_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (s_valid_i) state_d = S_SEARCH;
      end
      S_SEARCH: begin
        state_d = S_PLACE;
      end
      S_PLACE: begin
        if (sts_i.out_free) state_d = s_valid_i ? S_SEARCH : S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    s_ready_o = 1'b0;
    cmd_o     = '0;
    unique case (state_q)
      S_IDLE: begin
        s_ready_o = 1'b1;
      end
      S_SEARCH: begin
        cmd_o.search = 1'b1;
      end
      S_PLACE: begin
        s_ready_o    = sts_i.out_free;
        cmd_o.finish = sts_i.out_free;
      end
      default: ;
    endcase
    cmd_o.load = s_valid_i && s_ready_o;
  end

endmodule

`default_nettype wire

// ===== hdl/ksq_dp.sv =====
// ----------------------------------------------------------------------------
// ksq_dp
// Slot array with per-slot compare cells, occupancy and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ksq_dp (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  ksq_pkg::cmd_t                   cmd_i,
  output ksq_pkg::sts_t                   sts_o,
  input  wire [ksq_pkg::S_DATA_W-1:0]     s_data_i,
  output logic                            m_valid_o,
  input  wire                             m_ready_i,
  output logic [ksq_pkg::M_DATA_W-1:0]    m_data_o
);
  import ksq_pkg::*;

  logic [KEY_W-1:0]  key_q;
  logic [31:0]       prio_q;
  logic              found_q;
  logic [CNT_W-1:0]  occ_q, occ_d;

  logic [KEY_W-1:0]  slot_key_q  [CAPACITY];
  logic [PRIO_W-1:0] slot_prio_q [CAPACITY];
  logic [KEY_W-1:0]  slot_key_d  [CAPACITY];
  logic [PRIO_W-1:0] slot_prio_d [CAPACITY];

  logic [CAPACITY-1:0] valid, match, ge, shifted;
  logic                found, positive, place_en;
  status_e             status;
  logic [KEY_W-1:0]    head_key;
  logic [PRIO_W-1:0]   head_prio;

  logic                m_valid_q;
  logic [M_DATA_W-1:0] m_data_q;

  assign positive = !prio_q[31] && (prio_q != 32'd0);
  assign found    = |match;

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      valid[i]   = CNT_W'(i) < occ_q;
      match[i]   = valid[i] && (slot_key_q[i] == key_q);
      ge[i]      = valid[i] && (slot_prio_q[i] >= prio_q[PRIO_W-1:0]);
      shifted[i] = |(match & ({CAPACITY{1'b1}} >> (CAPACITY - 1 - i)));
    end
  end

  // Decide the outcome in the placement cycle.
  always_comb begin
    place_en = 1'b0;
    if (found_q) begin
      status   = positive ? STAT_UPDATED : STAT_REMOVED;
      place_en = positive;
    end else if (!positive) begin
      status = STAT_IGNORED;
    end else if (occ_q < CNT_W'(CAPACITY)) begin
      status   = STAT_INSERTED;
      place_en = 1'b1;
    end else begin
      status = STAT_DROPPED;
    end
  end

  // Slot cells: close the gap on search, open one on placement.
  always_comb begin
    occ_d = occ_q;
    for (int i = 0; i < CAPACITY; i++) begin
      slot_key_d[i]  = slot_key_q[i];
      slot_prio_d[i] = slot_prio_q[i];
    end
    if (cmd_i.search) begin
      for (int i = 0; i < CAPACITY - 1; i++) begin
        if (shifted[i]) begin
          slot_key_d[i]  = slot_key_q[i+1];
          slot_prio_d[i] = slot_prio_q[i+1];
        end
      end
      if (found) occ_d = occ_q - 1'b1;
    end else if (cmd_i.finish && place_en) begin
      for (int i = 0; i < CAPACITY; i++) begin
        if (!ge[i]) begin
          if (i == 0 || ge[(i == 0) ? 0 : i-1]) begin
            slot_key_d[i]  = key_q;
            slot_prio_d[i] = prio_q[PRIO_W-1:0];
          end else begin
            slot_key_d[i]  = slot_key_q[(i == 0) ? 0 : i-1];
            slot_prio_d[i] = slot_prio_q[(i == 0) ? 0 : i-1];
          end
        end
      end
      occ_d = occ_q + 1'b1;
    end
  end

  assign head_key  = (occ_d != '0) ? slot_key_d[0]  : '0;
  assign head_prio = (occ_d != '0) ? slot_prio_d[0] : '0;

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < CAPACITY; i++) begin
      slot_key_q[i]  <= slot_key_d[i];
      slot_prio_q[i] <= slot_prio_d[i];
    end
    if (cmd_i.load) begin
      key_q  <= s_data_i[31:0];
      prio_q <= s_data_i[63:32];
    end
    if (cmd_i.search) found_q <= found;
    if (cmd_i.finish) begin
      m_data_q <= {1'b0, COUNT_W'(occ_d), head_prio, head_key, status};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      occ_q <= occ_d;
      if (cmd_i.finish) begin
        m_valid_q <= 1'b1;
      end else if (m_ready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  assign sts_o.out_free = !m_valid_q || m_ready_i;
  assign m_valid_o      = m_valid_q;
  assign m_data_o       = m_data_q;

`ifndef SYNTHESIS
  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= CNT_W'(CAPACITY))
    else $error("occupancy above capacity");

  a_keys_unique: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.search |-> $onehot0(match))
    else $error("key held in more than one slot");

  a_sorted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish |-> ((ge & (ge + 1'b1)) == '0))
    else $error("slots not in descending priority order");

  a_drop_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.finish && status == STAT_DROPPED) |=> occ_q == $past(occ_q))
    else $error("dropped insert changed occupancy");
`endif

endmodule

`default_nettype wire

// ===== hdl/keyed_sorted_priority_queue_top.sv =====
// ----------------------------------------------------------------------------
// keyed_sorted_priority_queue_top
// Sorted priority queue of up to CAPACITY distinct keys with key update.
// ----------------------------------------------------------------------------
// Channel   Dir  Word contents (lowest bit first)
// s_axis    in   entry_key[31:0], priority_req[63:32]
// m_axis    out  status[2:0], head_key[34:3], head_priority[65:35],
//                entry_count[70:66], zero pad [71]
//
// An accepted word passes through a search step, which compares its key against
// every slot in parallel and closes the gap of a matching entry, and then a
// placement step, which finds the insertion point by parallel priority compare
// and shifts the tail. A new word is taken in the placement cycle of the
// previous one, once the result register is free to take its result.
// The result register holds one word; if it is still unread when the next
// result is ready, the placement cycle waits and the input stalls.
// Reset empties the queue at once; slot contents need no clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module keyed_sorted_priority_queue_top (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          s_axis_tvalid,
  output logic                         s_axis_tready,
  // entry_key [31:0], priority_req [63:32]
  input  wire [ksq_pkg::S_DATA_W-1:0]  s_axis_tdata,
  output logic                         m_axis_tvalid,
  input  wire                          m_axis_tready,
  // status [2:0], head_key [34:3], head_priority [65:35], entry_count [70:66]
  output logic [ksq_pkg::M_DATA_W-1:0] m_axis_tdata
);
  import ksq_pkg::*;

  // Commands flow from the sequencer to the datapath, status flows back.
  cmd_t cmd;
  sts_t sts;

  ksq_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  // The datapath owns the slots, the occupancy count and the result word.
  ksq_dp u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .sts_o     (sts),
    .s_data_i  (s_axis_tdata),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .m_data_o  (m_axis_tdata)
  );

endmodule

`default_nettype wire
